// ===== hw/rtl/tcgr_pkg.sv =====
// Shared types and constants for the text console glyph renderer.
// Holds field widths, command and register codes, and console geometry.
// No dependencies.
package tcgr_pkg;

    // Console geometry.
    localparam int GLYPH_BYTES = 16;
    localparam int GLYPH_W     = 8;
    localparam int TEXT_ROWS   = 64;
    localparam int MAX_WIDTH   = 8192;

    // Field widths.
    localparam int CODE_W   = 8;
    localparam int GROW_W   = $clog2(GLYPH_BYTES);
    localparam int BITS_W   = 8;
    localparam int OFF_W    = 23;
    localparam int INK_W    = 32;
    localparam int COL_W    = 13;
    localparam int PPL_W    = 14;
    localparam int ROW_W    = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1;
    localparam int Y_W      = ROW_W + GROW_W;
    localparam int ADDR_W   = CODE_W + GROW_W;
    localparam int FONT_DEPTH = 1 << ADDR_W;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Register reset values.
    localparam logic [PPL_W-1:0] PPL_RESET = PPL_W'(1024);
    localparam logic [INK_W-1:0] INK_RESET = '1;

    // Character that moves the cursor to the next text row.
    localparam logic [CODE_W-1:0] NEWLINE_CODE = CODE_W'(10);

    // Input item commands.
    typedef enum logic {
        CMD_PRINT = 1'b0,
        CMD_LOAD  = 1'b1
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIXELS_PER_LINE = 2'd0,
        REG_INK_COLOR       = 2'd1
    } t_reg_idx;

endpackage

// ===== hw/rtl/text_console_glyph_renderer_core.sv =====
// Top level of the text console glyph renderer: font memory, cursor and row emitter.
// Depends on tcgr_pkg for widths, codes and console geometry.

// A load beat writes one glyph row byte into the 4096 x 8 font memory. A newline
// print beat moves the cursor and gives no result. Any other printed character
// streams sixteen row beats, one per cycle while the output is not stalled. A
// character holds the input until every glyph row has been issued, because the
// single read port of the font memory is read once per row; output stalls lengthen
// that. The first row beat passes the read stage and the output register before it
// is offered. Each row beat carries the pixel offset of the row within the frame
// (base address added downstream), the lit mask and the ink color, with o_last on
// the sixteenth row. The input is stalled while a character's rows are being issued.
// Font entries that were never loaded read back as unknown values; there is no
// clearing pass.
module text_console_glyph_renderer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input item channel.
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_cmd,
    input  logic [tcgr_pkg::CODE_W-1:0]     i_char_code,
    input  logic [tcgr_pkg::GROW_W-1:0]     i_glyph_row,
    input  logic [tcgr_pkg::BITS_W-1:0]     i_row_bits,
    // Result channel.
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [tcgr_pkg::OFF_W-1:0]      o_pixel_offset,
    output logic [tcgr_pkg::BITS_W-1:0]     o_lit_mask,
    output logic [tcgr_pkg::INK_W-1:0]      o_ink,
    output logic                            o_last,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcgr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tcgr_pkg::*;

    // Configuration registers.
    logic [PPL_W-1:0]   r_ppl;
    logic [INK_W-1:0]   r_ink;

    // Cursor.
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;

    // Character being drawn.
    logic               r_busy;
    logic [CODE_W-1:0]  r_code;
    logic [GROW_W-1:0]  r_cnt;
    logic [COL_W-1:0]   r_draw_col;
    logic [ROW_W-1:0]   r_draw_row;

    // Read stage: font read in flight plus row product.
    logic               r_v1;
    logic [OFF_W-1:0]   r_prod1;
    logic [COL_W-1:0]   r_col1;
    logic               r_last1;

    // Font memory.
    logic [BITS_W-1:0]  r_font [FONT_DEPTH];
    logic [BITS_W-1:0]  r_font_q;

    // Output register.
    logic               r_out_valid;
    logic [OFF_W-1:0]   r_out_off;
    logic [BITS_W-1:0]  r_out_mask;
    logic [INK_W-1:0]   r_out_ink;
    logic               r_out_last;

    logic               in_accept;
    logic               is_load;
    logic               is_newline;
    logic               out_adv;
    logic               issue;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [Y_W-1:0]     y_pix;
    logic [PPL_W-1:0]   width_eff;
    logic [PPL_W:0]     col_adv;
    logic [PPL_W:0]     col_probe;
    logic               wrap;
    logic [ROW_W-1:0]   row_next;
    logic [COL_W-1:0]   n_col;
    logic [ROW_W-1:0]   n_row;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_busy;
    assign in_accept   = i_valid && !r_busy;
    assign is_load     = (t_cmd'(i_cmd) == CMD_LOAD);
    assign is_newline  = (i_char_code == NEWLINE_CODE);

    // Output register moves when empty or when its beat is taken.
    assign out_adv = !r_out_valid || !i_stall;
    // Issue a glyph row read when the read stage is free or moving on.
    assign issue   = r_busy && (!r_v1 || out_adv);

    assign rd_addr = {r_code, r_cnt};
    assign wr_addr = {i_char_code, i_glyph_row};
    assign y_pix   = {r_draw_row, r_cnt};

    // Cursor advance: the effective width is capped so the column fits in 13 bits.
    always_comb begin
        width_eff = (r_ppl < PPL_W'(MAX_WIDTH)) ? r_ppl : PPL_W'(MAX_WIDTH);
        col_adv   = (PPL_W+1)'(r_col) + (PPL_W+1)'(GLYPH_W);
        col_probe = col_adv + (PPL_W+1)'(GLYPH_W);
        wrap      = col_probe > (PPL_W+1)'(width_eff);
        row_next  = (r_row == ROW_W'(TEXT_ROWS - 1)) ? '0 : r_row + ROW_W'(1);
    end

    // Next cursor position for the accepted item.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_accept && !is_load) begin
            if (is_newline || wrap) begin
                n_col = '0;
                n_row = row_next;
            end else begin
                n_col = col_adv[COL_W-1:0];
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppl <= PPL_RESET;
            r_ink <= INK_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_PIXELS_PER_LINE: r_ppl <= i_cfg_data[PPL_W-1:0];
                REG_INK_COLOR:       r_ink <= i_cfg_data[INK_W-1:0];
                default: ;
            endcase
        end
    end

    // Cursor and character sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (in_accept && !is_load && !is_newline) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (issue) begin
                r_cnt <= r_cnt + GROW_W'(1);
                if (r_cnt == GROW_W'(GLYPH_BYTES - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Position and code of the character being drawn.
    always_ff @(posedge i_clk) begin
        if (in_accept && !is_load && !is_newline) begin
            r_code     <= i_char_code;
            r_draw_col <= r_col;
            r_draw_row <= r_row;
        end
    end

    // Font memory write port.
    always_ff @(posedge i_clk) begin
        if (in_accept && is_load) begin
            r_font[wr_addr] <= i_row_bits;
        end
    end

    // Font memory read port; the read data holds while no row is issued.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_font_q <= r_font[rd_addr];
        end
    end

    // Read stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (issue) begin
            r_v1 <= 1'b1;
        end else if (out_adv) begin
            r_v1 <= 1'b0;
        end
    end

    // Row product y * stride, taken modulo 2^23, alongside the font read.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_prod1 <= OFF_W'(y_pix) * OFF_W'(r_ppl);
            r_col1  <= r_draw_col;
            r_last1 <= (r_cnt == GROW_W'(GLYPH_BYTES - 1));
        end
    end

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_v1;
        end
    end

    // Output payload: column added to the row product.
    always_ff @(posedge i_clk) begin
        if (out_adv && r_v1) begin
            r_out_off  <= r_prod1 + OFF_W'(r_col1);
            r_out_mask <= r_font_q;
            r_out_ink  <= r_ink;
            r_out_last <= r_last1;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pixel_offset = r_out_off;
    assign o_lit_mask     = r_out_mask;
    assign o_ink          = r_out_ink;
    assign o_last         = r_out_last;

endmodule
